FILE: src/unordered_id_set_table_assert.svh
// Assertion macros shared by the set table RTL.
`ifndef UNORDERED_ID_SET_TABLE_ASSERT_SVH
`define UNORDERED_ID_SET_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a condition on every clock edge outside reset.
`define UIST_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define UIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define UIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define UIST_ASSERT(lbl, clk, rst_n, expr, msg)
`define UIST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UIST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/uist_pkg.sv
package uist_pkg;

  localparam int ID_W      = 32;
  localparam int OPC_W     = 2;
  localparam int IDX_IN_W  = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: src/uist_in_if.sv
interface uist_in_if import uist_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [ID_W-1:0]     id_value;
  logic [IDX_IN_W-1:0] entry_index;

  modport source (output valid, opcode, id_value, entry_index, input ready);
  modport sink   (input valid, opcode, id_value, entry_index, output ready);

endinterface

FILE: src/uist_out_if.sv
interface uist_out_if import uist_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 found;
  logic [IDX_IN_W-1:0]  position;
  logic [ID_W-1:0]      entry_value;
  logic [CNT_OUT_W-1:0] element_count;

  modport source (output valid, status, found, position, entry_value, element_count,
                  input ready);
  modport sink   (input valid, status, found, position, entry_value, element_count,
                  output ready);

endinterface

FILE: src/uist_ram.sv
module uist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/unordered_id_set_table.sv
// Steps: read fetches, applies and finishes; find scans and finishes; add scans, applies and
//   finishes; remove scans, fetches, applies and finishes (one entry compared per cycle
//   through the store's read port); a request rejected before the scan finishes at once.
// Throughput: one request at a time; a new request is taken while the previous result still
//   waits in the output register.
// Reset (synchronous, rst_n low): count cleared, reserved id set to all ones, output
//   emptied; the id store is not cleared, only slots below the count are ever read.
module unordered_id_set_table import uist_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ID_W-1:0]  cfg_wr_data,
  uist_in_if.sink          in_chan,
  uist_out_if.source       out_chan
);

`include "unordered_id_set_table_assert.svh"

  // Keys are compared on their low ID_BITS bits, never more than the id field carries.
  localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_APPLY,
    ST_DONE
  } state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [KEY_W-1:0]     key_r;
  logic [ID_W-1:0]      reserved_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     scan_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_slot_r;
  logic [IDX_W-1:0]     slot_r;
  logic [IDX_W-1:0]     fetch_addr_r;

  // Result under construction.
  logic                 res_status_r;
  logic                 res_found_r;
  logic [IDX_IN_W-1:0]  res_pos_r;
  logic [ID_W-1:0]      res_value_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_status_r;
  logic                 out_found_r;
  logic [IDX_IN_W-1:0]  out_pos_r;
  logic [ID_W-1:0]      out_value_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [KEY_W-1:0]     ram_rdata;

  logic                 in_acc;
  logic [KEY_W-1:0]     in_key;
  logic                 in_reserved;
  logic                 set_full;
  logic                 idx_ok;
  logic                 scan_hit;
  logic                 scan_more;
  logic                 out_free;
  logic                 out_load;
  logic [IDX_W-1:0]     last_idx;

  uist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Take a request only between operations; the output register decouples the sink.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign in_key      = in_chan.id_value[KEY_W-1:0];
  assign in_reserved = (in_key == reserved_r[KEY_W-1:0]);
  assign set_full    = (cnt_r == CNT_W'(CAPACITY));
  // Any index below the count is also below the capacity.
  assign idx_ok      = (CMP_W'(in_chan.entry_index) < CMP_W'(cnt_r));
  assign last_idx    = IDX_W'(cnt_r - CNT_W'(1));

  // The store returns the entry issued last cycle; compare it against the key.
  assign scan_hit  = cmp_vld_r && (ram_rdata == key_r);
  assign scan_more = (scan_r < cnt_r);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_load  = (state_r == ST_DONE) && out_free;

  // Walk the slots during the scan, otherwise fetch the selected slot.
  assign ram_raddr = (state_r == ST_SCAN) ? scan_r[IDX_W-1:0] : fetch_addr_r;

  // Write back only in the apply step: append for add, fill the hole for remove.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = key_r;
    if (state_r == ST_APPLY) begin
      case (op_r)
        OP_ADD: begin
          ram_we = 1'b1;
        end
        OP_REMOVE: begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = ram_rdata;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      reserved_r  <= '1;
    end else begin
      if (cfg_wr_en) begin
        reserved_r <= cfg_wr_data;
      end

      // Load a finished result, else drop the output once the sink takes it.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r         <= op_t'(in_chan.opcode);
            key_r        <= in_key;
            scan_r       <= '0;
            cmp_vld_r    <= 1'b0;
            res_status_r <= STATUS_ERR;
            res_found_r  <= 1'b0;
            res_pos_r    <= '0;
            res_value_r  <= '0;
            fetch_addr_r <= IDX_W'(in_chan.entry_index);
            unique case (op_t'(in_chan.opcode))
              OP_ADD: begin
                state_r <= (in_reserved || set_full) ? ST_DONE : ST_SCAN;
              end
              OP_REMOVE, OP_FIND: begin
                state_r <= in_reserved ? ST_DONE : ST_SCAN;
              end
              OP_READ: begin
                state_r <= idx_ok ? ST_FETCH : ST_DONE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_hit) begin
            slot_r    <= cmp_slot_r;
            cmp_vld_r <= 1'b0;
            unique case (op_r)
              OP_REMOVE: begin
                // Fetch the last entry to move into the freed slot.
                fetch_addr_r <= last_idx;
                state_r      <= ST_FETCH;
              end
              OP_FIND: begin
                res_status_r <= STATUS_OK;
                res_found_r  <= 1'b1;
                res_pos_r    <= IDX_IN_W'(cmp_slot_r);
                state_r      <= ST_DONE;
              end
              default: begin
                // Duplicate id on add.
                state_r <= ST_DONE;
              end
            endcase
          end else if (scan_more) begin
            cmp_vld_r  <= 1'b1;
            cmp_slot_r <= scan_r[IDX_W-1:0];
            scan_r     <= scan_r + CNT_W'(1);
          end else begin
            // Whole set searched without a match.
            cmp_vld_r <= 1'b0;
            state_r   <= (op_r == OP_ADD) ? ST_APPLY : ST_DONE;
          end
        end

        ST_FETCH: begin
          state_r <= ST_APPLY;
        end

        ST_APPLY: begin
          res_status_r <= STATUS_OK;
          case (op_r)
            OP_ADD:    cnt_r <= cnt_r + CNT_W'(1);
            OP_REMOVE: cnt_r <= cnt_r - CNT_W'(1);
            OP_READ:   res_value_r <= ID_W'(ram_rdata);
            default:   cnt_r <= cnt_r;
          endcase
          state_r <= ST_DONE;
        end

        ST_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_status_r <= res_status_r;
            out_found_r  <= res_found_r;
            out_pos_r    <= res_pos_r;
            out_value_r  <= res_value_r;
            out_cnt_r    <= CNT_OUT_W'(cnt_r);
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.position      = out_pos_r;
  assign out_chan.entry_value   = out_value_r;
  assign out_chan.element_count = out_cnt_r;

  `UIST_ASSERT(a_cnt_cap, clk, rst_n, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `UIST_ASSERT_IMP(a_cnt_upd, clk, rst_n, cnt_r != $past(cnt_r), $past(state_r) == ST_APPLY, "count moved")
  `UIST_ASSERT_NXT(a_acc_busy, clk, rst_n, in_acc, state_r != ST_IDLE, "accept left no work")
  `UIST_ASSERT_IMP(a_found_ok, clk, rst_n, out_valid_r && out_found_r, out_status_r == STATUS_OK, "found with error")

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uist_pkg::*;

  // Table depth of the block as built (CAPACITY default).
  localparam int TABLE_DEPTH  = 16;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  // Fill and drain alternate every this many requests inside a phase.
  localparam int SWING_ITEMS  = 40;
  // Time given after the last response, past the longest remove.
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 400;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic [IDX_IN_W-1:0]  position;
    logic [ID_W-1:0]      entry_value;
    logic [CNT_OUT_W-1:0] element_count;
  } set_result_t;

  // Scoreboard: mirrors the id set and holds the expected response of every
  // request that the block has accepted, oldest first.
  class id_set_scoreboard;
    logic [ID_W-1:0] slots [TABLE_DEPTH];
    int unsigned     used;
    logic [ID_W-1:0] reserved;
    set_result_t     expected_q [$];

    function new();
      used     = 0;
      reserved = '1;
    endfunction

    function void set_reserved(input logic [ID_W-1:0] value);
      reserved = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [ID_W-1:0] pick_present();
      return slots[$urandom_range(0, used - 1)];
    endfunction

    // Search only the live slots; -1 when the id is not held.
    function int slot_of(input logic [ID_W-1:0] id);
      for (int k = 0; k < used; k++) begin
        if (slots[k] == id) return k;
      end
      return -1;
    endfunction

    function void note_request(input op_t op, input logic [ID_W-1:0] id,
                               input logic [IDX_IN_W-1:0] idx);
      set_result_t r;
      int          hit;
      r        = '0;
      r.status = STATUS_ERR;
      hit      = slot_of(id);
      case (op)
        OP_ADD: begin
          if (id != reserved && used < TABLE_DEPTH && hit < 0) begin
            slots[used] = id;
            used++;
            r.status = STATUS_OK;
          end
        end
        OP_REMOVE: begin
          // swap-remove: last live entry moves into the freed slot
          if (id != reserved && hit >= 0) begin
            slots[hit] = slots[used - 1];
            used--;
            r.status = STATUS_OK;
          end
        end
        OP_FIND: begin
          if (id != reserved && hit >= 0) begin
            r.status   = STATUS_OK;
            r.found    = 1'b1;
            r.position = IDX_IN_W'(hit);
          end
        end
        default: begin
          if (idx < used) begin
            r.status      = STATUS_OK;
            r.entry_value = slots[idx];
          end
        end
      endcase
      r.element_count = CNT_OUT_W'(used);
      expected_q.push_back(r);
    endfunction

    // Empty string when the response matches, else the differing fields.
    function string check_result(input set_result_t got);
      set_result_t want;
      string       diff;
      if (expected_q.size() == 0)
        return $sformatf(" response with no request waiting, count %0d", got.element_count);
      want = expected_q.pop_front();
      diff = "";
      if (got.status !== want.status)
        diff = {diff, $sformatf(" status %0b/%0b", want.status, got.status)};
      if (got.found !== want.found)
        diff = {diff, $sformatf(" found %0b/%0b", want.found, got.found)};
      if (got.position !== want.position)
        diff = {diff, $sformatf(" position %0d/%0d", want.position, got.position)};
      if (got.entry_value !== want.entry_value)
        diff = {diff, $sformatf(" entry_value %h/%h", want.entry_value, got.entry_value)};
      if (got.element_count !== want.element_count)
        diff = {diff, $sformatf(" count %0d/%0d", want.element_count, got.element_count)};
      return diff;
    endfunction
  endclass

  logic            clk   = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_wr_en;
  logic [ID_W-1:0] cfg_wr_data;

  uist_in_if  req_bus ();
  uist_out_if rsp_bus ();

  id_set_scoreboard sb;

  logic [ID_W-1:0] id_pool [POOL_SIZE];
  bit              calm = 1'b0;
  bit              long_hold_done = 1'b0;
  int unsigned     results_seen = 0;
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  set_result_t     seen_result;
  string           verdict;

  unordered_id_set_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (req_bus.sink),
    .out_chan    (rsp_bus.source)
  );

  // 8 ns clock, half high and half low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t, response %0d (want/got):%s", $time, results_seen, what);
  endtask

  // Offer one request and hold it until the block takes it. Leave valid high
  // on return so a back-to-back request does not toggle it within a step.
  task automatic send_request(input op_t op, input logic [ID_W-1:0] id,
                              input logic [IDX_IN_W-1:0] idx);
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= op;
    req_bus.id_value    <= id;
    req_bus.entry_index <= idx;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    // Record at the accepting edge itself, so the expectation is in place
    // before any later check of what is still outstanding.
    sb.note_request(op, id, idx);
  endtask

  // Drop valid for a random burst now and then, unless in the calm tail.
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Write the reserved id only with the block idle: nothing offered and
  // every expected response delivered. Each request yields a response, so
  // an empty queue means the block has finished its work.
  task automatic write_reserved(input logic [ID_W-1:0] value);
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reserved(value);
  endtask

  // Corner cases with the reset value of the reserved id (all ones).
  task automatic directed_part();
    send_request(OP_READ, '0, '0);                       // read on an empty table
    send_request(OP_REMOVE, 32'h0000_0005, '0);          // remove from empty table
    send_request(OP_FIND, 32'h0000_0005, '0);            // find on empty table
    send_request(OP_ADD, 32'hFFFF_FFFF, '0);             // reserved id rejected
    send_request(OP_ADD, id_pool[0], '0);                // id zero accepted
    send_request(OP_ADD, id_pool[0], '0);                // duplicate rejected
    for (int k = 1; k < TABLE_DEPTH; k++)
      send_request(OP_ADD, id_pool[k], '0);              // fill up to capacity
    send_request(OP_ADD, id_pool[TABLE_DEPTH], '0);      // add to a full table
    send_request(OP_FIND, id_pool[TABLE_DEPTH-1], '0);   // hit in the top slot
    send_request(OP_READ, '0, 4'hF);                     // read of the top slot
    send_request(OP_REMOVE, id_pool[0], '0);             // slot 0, top entry moves in
    send_request(OP_READ, '0, 4'hF);                     // index now past the count
    send_request(OP_FIND, 32'hFFFF_FFFF, '0);            // find of reserved id
    send_request(OP_REMOVE, 32'hFFFF_FFFF, '0);          // remove of reserved id
  endtask

  // Mostly well-formed traffic on a small id pool so that hits, duplicates,
  // full and empty tables all come up; alternate fill-heavy and drain-heavy
  // stretches to sweep the count over its whole range.
  task automatic random_request(input int unsigned n);
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [IDX_IN_W-1:0] idx;
    int unsigned         roll;
    bit                  filling;
    filling = ((n / SWING_ITEMS) % 2) == 0;
    roll    = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 60)      op = OP_ADD;
      else if (roll < 75) op = OP_REMOVE;
      else if (roll < 88) op = OP_FIND;
      else                op = OP_READ;
    end else begin
      if (roll < 15)      op = OP_ADD;
      else if (roll < 60) op = OP_REMOVE;
      else if (roll < 80) op = OP_FIND;
      else                op = OP_READ;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55)                     id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (roll < 75 && sb.used > 0) id = sb.pick_present();
    else if (roll < 90)                id = $urandom();
    else                               id = sb.reserved;
    // Bias reads toward live slots, but keep out-of-range indexes coming.
    if (sb.used > 0 && $urandom_range(0, 3) != 0)
      idx = IDX_IN_W'($urandom_range(0, sb.used - 1));
    else
      idx = IDX_IN_W'($urandom_range(0, TABLE_DEPTH - 1));
    sender_pause();
    send_request(op, id, idx);
  endtask

  function automatic logic [ID_W-1:0] reserved_for_phase(input int phase);
    case (phase)
      1:       return 32'h0000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return id_pool[2];
      4:       return $urandom();
      default: return 32'h8000_0001;
    endcase
  endfunction

  // Main sequence: reset, directed corners, then random phases, each after the
  // first with a new reserved id written while the block is idle.
  initial begin
    logic [ID_W-1:0] cand;
    bit              fresh;
    sb = new();
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = OP_ADD;
    req_bus.id_value    = '0;
    req_bus.entry_index = '0;

    // Build a pool of distinct ids, none of them all ones, with both extremes.
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFE;
    for (int k = 2; k < POOL_SIZE; k++) begin
      do begin
        cand  = $urandom();
        fresh = (cand != 32'hFFFF_FFFF);
        for (int j = 0; j < k; j++) begin
          if (id_pool[j] == cand) fresh = 1'b0;
        end
      end while (!fresh);
      id_pool[k] = cand;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_part();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) write_reserved(reserved_for_phase(phase));
      // No idling at all in the final phase.
      calm = (phase == PHASES - 1);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) random_request(n);
    end
    req_bus.valid <= 1'b0;

    // Wait for the last responses, then give the block time to show extras.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("unordered_id_set_table verification clean");
    end else begin
      $display("unordered_id_set_table verification failed");
    end
    $finish;
  end

  // Response side: ready in random bursts, one long hold-off so the block
  // fills and stalls its input, and steady ready in the calm tail.
  initial begin
    rsp_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Check every delivered response against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      seen_result.status        = rsp_bus.status;
      seen_result.found         = rsp_bus.found;
      seen_result.position      = rsp_bus.position;
      seen_result.entry_value   = rsp_bus.entry_value;
      seen_result.element_count = rsp_bus.element_count;
      verdict = sb.check_result(seen_result);
      if (verdict != "") report_mismatch(verdict);
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("unordered_id_set_table verification failed");
      $finish;
    end
  end

endmodule
